[sv/lpfp_pkg.sv]
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared field codes, status codes and the per-byte result type of the
// length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

  localparam int unsigned PREFIX_BYTES = 4;

  // field kinds, also the parser phase codes
  localparam logic [3:0] K_TOTAL   = 4'd0;
  localparam logic [3:0] K_TYPE    = 4'd1;
  localparam logic [3:0] K_IDLEN   = 4'd2;
  localparam logic [3:0] K_ID      = 4'd3;
  localparam logic [3:0] K_HCOUNT  = 4'd4;
  localparam logic [3:0] K_KEYLEN  = 4'd5;
  localparam logic [3:0] K_KEY     = 4'd6;
  localparam logic [3:0] K_VALLEN  = 4'd7;
  localparam logic [3:0] K_VAL     = 4'd8;
  localparam logic [3:0] K_BODYLEN = 4'd9;
  localparam logic [3:0] K_BODY    = 4'd10;
  localparam logic [3:0] K_TRAIL   = 4'd11;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_GOOD     = 2'd1;
  localparam logic [1:0] ST_LEN_ERR  = 2'd2;
  localparam logic [1:0] ST_OVERRUN  = 2'd3;

  localparam logic [32:0] SEEN_MAX = {33{1'b1}};

  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  kind;
    logic [15:0] hnum;
    logic        flast;
    logic        fend;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

[sv/length_prefixed_frame_parser.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Tags each byte of a received buffer with its frame field and reports the
// frame's status on the buffer's last byte.
// ----------------------------------------------------------------------------
//  channel  dir  width            contents
//  s_*      in   tdata 8, tlast   one buffer byte, tlast = buffer_last
//  m_*      out  tdata 32, tuser 4, tlast
//                                 tagged byte, tuser = field kind,
//                                 tlast = frame_end (status valid there)
//
//  One byte per cycle sustained while m_tready stays high. A byte passes the
//  input register, then the parser update (one 33-bit add and compare for
//  the length check) into the output register.
//  rst is synchronous; it empties both registers and returns the parser to
//  "expect total length".
//  A stall on m_tready holds the output; an empty input register still takes
//  one more transaction before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // buffer_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [7:0] out_byte, [23:8] header_number,
                                      // [24] field_last, [26:25] status, rest 0
  output logic [3:0]       m_tuser,   // [3:0] field_kind
  output logic             m_tlast    // frame_end
);

  // input register
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // output register
  logic              out_valid;
  lpfp_pkg::result_t out_res;

  lpfp_pkg::result_t step_res;
  logic              advance;

  // move the held byte through the parser when the output slot frees up
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  lpfp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .data    (in_data),
    .last    (in_last),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res.status, out_res.flast, out_res.hnum, out_res.data};
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.fend;

endmodule

`default_nettype wire

[sv/lpfp_core.sv]
// ----------------------------------------------------------------------------
// lpfp_core
// Parser state and the per-byte update; result is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      data,
  input  wire logic            last,
  output lpfp_pkg::result_t    result
);

  logic [3:0]  phase,    phase_next;
  logic [1:0]  fbc,      fbc_next;
  logic [31:0] acc,      acc_next;
  logic [31:0] total,    total_next;
  logic [32:0] seen,     seen_next;
  logic [15:0] str_rem,  str_rem_next;
  logic [15:0] hdr_rem,  hdr_rem_next;
  logic [15:0] cur_hdr,  cur_hdr_next;
  logic [31:0] body_rem, body_rem_next;

  logic [31:0] acc_sh;
  logic        done2, done4;
  logic        total_known;
  logic [32:0] expect_len;
  logic [15:0] hdr_dec;

  assign acc_sh  = {acc[23:0], data};
  assign done2   = (fbc != 2'd0);
  assign done4   = (fbc == 2'd3);
  assign hdr_dec = hdr_rem - 16'd1;

  always_comb begin
    phase_next    = phase;
    fbc_next      = fbc;
    acc_next      = acc;
    total_next    = total;
    str_rem_next  = str_rem;
    hdr_rem_next  = hdr_rem;
    cur_hdr_next  = cur_hdr;
    body_rem_next = body_rem;
    seen_next     = (seen == lpfp_pkg::SEEN_MAX) ? seen : seen + 33'd1;
    total_known   = (phase != lpfp_pkg::K_TOTAL);
    result.data   = data;
    result.kind   = phase;
    result.hnum   = 16'd0;
    result.flast  = 1'b0;
    result.fend   = last;
    result.status = lpfp_pkg::ST_BUSY;

    case (phase)
      lpfp_pkg::K_TOTAL: begin
        acc_next = acc_sh;
        fbc_next = done4 ? 2'd0 : fbc + 2'd1;
        if (done4) begin
          result.flast = 1'b1;
          total_next   = acc_sh;
          total_known  = 1'b1;
          phase_next   = lpfp_pkg::K_TYPE;
        end
      end
      lpfp_pkg::K_TYPE: begin
        result.flast = 1'b1;
        phase_next   = lpfp_pkg::K_IDLEN;
      end
      lpfp_pkg::K_IDLEN, lpfp_pkg::K_KEYLEN, lpfp_pkg::K_VALLEN: begin
        if (phase != lpfp_pkg::K_IDLEN) result.hnum = cur_hdr;
        acc_next = acc_sh;
        fbc_next = done2 ? 2'd0 : fbc + 2'd1;
        if (done2) begin
          result.flast = 1'b1;
          str_rem_next = acc_sh[15:0];
          if (acc_sh[15:0] != 16'd0) begin
            phase_next = phase + 4'd1;
          end else if (phase == lpfp_pkg::K_IDLEN) begin
            phase_next = lpfp_pkg::K_HCOUNT;
          end else if (phase == lpfp_pkg::K_KEYLEN) begin
            phase_next = lpfp_pkg::K_VALLEN;
          end else begin
            hdr_rem_next = hdr_dec;
            cur_hdr_next = cur_hdr + 16'd1;
            phase_next   = (hdr_dec == 16'd0) ? lpfp_pkg::K_BODYLEN : lpfp_pkg::K_KEYLEN;
          end
        end
      end
      lpfp_pkg::K_ID, lpfp_pkg::K_KEY, lpfp_pkg::K_VAL: begin
        if (phase != lpfp_pkg::K_ID) result.hnum = cur_hdr;
        str_rem_next = str_rem - 16'd1;
        if (str_rem_next == 16'd0) begin
          result.flast = 1'b1;
          if (phase == lpfp_pkg::K_ID) begin
            phase_next = lpfp_pkg::K_HCOUNT;
          end else if (phase == lpfp_pkg::K_KEY) begin
            phase_next = lpfp_pkg::K_VALLEN;
          end else begin
            hdr_rem_next = hdr_dec;
            cur_hdr_next = cur_hdr + 16'd1;
            phase_next   = (hdr_dec == 16'd0) ? lpfp_pkg::K_BODYLEN : lpfp_pkg::K_KEYLEN;
          end
        end
      end
      lpfp_pkg::K_HCOUNT: begin
        acc_next = acc_sh;
        fbc_next = done2 ? 2'd0 : fbc + 2'd1;
        if (done2) begin
          result.flast = 1'b1;
          hdr_rem_next = acc_sh[15:0];
          cur_hdr_next = 16'd0;
          phase_next   = (acc_sh[15:0] == 16'd0) ? lpfp_pkg::K_BODYLEN : lpfp_pkg::K_KEYLEN;
        end
      end
      lpfp_pkg::K_BODYLEN: begin
        acc_next = acc_sh;
        fbc_next = done4 ? 2'd0 : fbc + 2'd1;
        if (done4) begin
          result.flast  = 1'b1;
          body_rem_next = acc_sh;
          phase_next    = (acc_sh == 32'd0) ? lpfp_pkg::K_TRAIL : lpfp_pkg::K_BODY;
        end
      end
      lpfp_pkg::K_BODY: begin
        body_rem_next = body_rem - 32'd1;
        if (body_rem_next == 32'd0) begin
          result.flast = 1'b1;
          phase_next   = lpfp_pkg::K_TRAIL;
        end
      end
      default: begin
        result.kind  = lpfp_pkg::K_TRAIL;
        phase_next   = lpfp_pkg::K_TRAIL;
        result.flast = last;
      end
    endcase

    expect_len = {1'b0, total_next} + 33'(lpfp_pkg::PREFIX_BYTES);

    if (last) begin
      if (!total_known || (expect_len != seen_next)) begin
        result.status = lpfp_pkg::ST_LEN_ERR;
      end else if (phase_next != lpfp_pkg::K_TRAIL) begin
        result.status = lpfp_pkg::ST_OVERRUN;
      end else begin
        result.status = lpfp_pkg::ST_GOOD;
      end
      phase_next    = lpfp_pkg::K_TOTAL;
      fbc_next      = 2'd0;
      acc_next      = 32'd0;
      total_next    = 32'd0;
      seen_next     = 33'd0;
      str_rem_next  = 16'd0;
      hdr_rem_next  = 16'd0;
      cur_hdr_next  = 16'd0;
      body_rem_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= lpfp_pkg::K_TOTAL;
      fbc      <= 2'd0;
      acc      <= 32'd0;
      total    <= 32'd0;
      seen     <= 33'd0;
      str_rem  <= 16'd0;
      hdr_rem  <= 16'd0;
      cur_hdr  <= 16'd0;
      body_rem <= 32'd0;
    end else if (advance) begin
      phase    <= phase_next;
      fbc      <= fbc_next;
      acc      <= acc_next;
      total    <= total_next;
      seen     <= seen_next;
      str_rem  <= str_rem_next;
      hdr_rem  <= hdr_rem_next;
      cur_hdr  <= cur_hdr_next;
      body_rem <= body_rem_next;
    end
  end

endmodule

`default_nettype wire

[sv/lpfp_checker.sv]
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level checks on the frame parser's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic [3:0]  m_tuser,
  input  wire logic        m_tlast
);

  // status is reported only on the frame's final transaction
  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[26:25] == lpfp_pkg::ST_BUSY)
    else $error("status set before frame end");

  a_status_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[26:25] != lpfp_pkg::ST_BUSY)
    else $error("no status at frame end");

  // header index is zero outside key/value fields
  a_hnum_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser < lpfp_pkg::K_KEYLEN || m_tuser > lpfp_pkg::K_VAL)
    |-> m_tdata[23:8] == 16'd0)
    else $error("header number outside header fields");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

`default_nettype wire

[tb/tb_length_prefixed_frame_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_parser
// Self-checking bench for the length-prefixed frame parser. Buffers are sent
// with random gaps and the output side stalls at random. A scoreboard class
// tags every accepted byte with the field kind, header index, field_last and
// status that it should get, and compares each output transaction with the
// oldest pending tag. A few hand-built buffers come first. They are followed
// by random buffers: mostly well-formed frames, plus cut frames, frames with
// a wrong total length, noise and short buffers.
// ----------------------------------------------------------------------------

module tb_length_prefixed_frame_parser;

  localparam int NUM_BYTES   = 1700;  // random part stops once this many are sent
  localparam int STALL_LIMIT = 1000;  // cycles with no transaction at all
  localparam int PAYLOAD_CAP = 64;    // caps huge declared lengths in cut frames
  localparam int DRAIN_WAIT  = 6;     // pipeline is two deep; a little margin
  localparam int MAX_REPORTS = 10;

  typedef enum int {BUF_GOOD, BUF_CUT, BUF_BAD_TOTAL, BUF_NOISE, BUF_SHORT} buf_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the parser state per accepted byte and queues the
  // expected output transaction.
  // --------------------------------------------------------------------------
  class frame_tag_scoreboard;
    logic [3:0]  phase;
    logic [1:0]  fbc;          // bytes taken of the current multi-byte field
    logic [31:0] acc;          // big-endian length collector
    logic [31:0] frame_total;
    logic [32:0] seen;         // bytes in the current buffer, saturating
    logic [15:0] str_rem;
    logic [15:0] hdr_rem;
    logic [15:0] cur_hdr;
    logic [31:0] body_rem;

    lpfp_pkg::result_t expected_tags[$];
    int          failures;
    int          tags_checked;
    int          ends_by_status[4];
    logic [11:0] kinds_seen;

    function new();
      clear();
      failures = 0;
      tags_checked = 0;
      kinds_seen = '0;
      foreach (ends_by_status[i]) ends_by_status[i] = 0;
    endfunction

    function void clear();
      phase = lpfp_pkg::K_TOTAL;
      fbc = '0;
      acc = '0;
      frame_total = '0;
      seen = '0;
      str_rem = '0;
      hdr_rem = '0;
      cur_hdr = '0;
      body_rem = '0;
    endfunction

    // shift one byte into the collector; 1 when the field is complete
    function bit take_be(logic [7:0] b, int unsigned nbytes);
      acc = {acc[23:0], b};
      if (fbc + 1 >= nbytes) begin
        fbc = '0;
        return 1'b1;
      end
      fbc = fbc + 2'd1;
      return 1'b0;
    endfunction

    function void end_header();
      hdr_rem = hdr_rem - 16'd1;
      cur_hdr = cur_hdr + 16'd1;
      phase = (hdr_rem == 16'd0) ? lpfp_pkg::K_BODYLEN : lpfp_pkg::K_KEYLEN;
    endfunction

    function void predict_tag(logic [7:0] b, logic last);
      lpfp_pkg::result_t r;
      logic              total_known;
      logic [32:0]       want_seen;
      r = '0;
      r.data = b;
      r.kind = phase;
      r.fend = last;
      total_known = (phase != lpfp_pkg::K_TOTAL);
      if (seen != lpfp_pkg::SEEN_MAX) seen = seen + 33'd1;

      case (phase)
        lpfp_pkg::K_TOTAL: begin
          if (take_be(b, lpfp_pkg::PREFIX_BYTES)) begin
            r.flast = 1'b1;
            frame_total = acc;
            total_known = 1'b1;
            phase = lpfp_pkg::K_TYPE;
          end
        end
        lpfp_pkg::K_TYPE: begin
          r.flast = 1'b1;
          phase = lpfp_pkg::K_IDLEN;
        end
        lpfp_pkg::K_IDLEN, lpfp_pkg::K_KEYLEN, lpfp_pkg::K_VALLEN: begin
          if (phase != lpfp_pkg::K_IDLEN) r.hnum = cur_hdr;
          if (take_be(b, 2)) begin
            r.flast = 1'b1;
            str_rem = acc[15:0];
            if (str_rem != 16'd0) phase = phase + 4'd1;  // length -> its string
            else if (phase == lpfp_pkg::K_IDLEN) phase = lpfp_pkg::K_HCOUNT;
            else if (phase == lpfp_pkg::K_KEYLEN) phase = lpfp_pkg::K_VALLEN;
            else end_header();
          end
        end
        lpfp_pkg::K_ID, lpfp_pkg::K_KEY, lpfp_pkg::K_VAL: begin
          if (phase != lpfp_pkg::K_ID) r.hnum = cur_hdr;
          str_rem = str_rem - 16'd1;
          if (str_rem == 16'd0) begin
            r.flast = 1'b1;
            if (phase == lpfp_pkg::K_ID) phase = lpfp_pkg::K_HCOUNT;
            else if (phase == lpfp_pkg::K_KEY) phase = lpfp_pkg::K_VALLEN;
            else end_header();
          end
        end
        lpfp_pkg::K_HCOUNT: begin
          if (take_be(b, 2)) begin
            r.flast = 1'b1;
            hdr_rem = acc[15:0];
            cur_hdr = '0;
            phase = (hdr_rem == 16'd0) ? lpfp_pkg::K_BODYLEN : lpfp_pkg::K_KEYLEN;
          end
        end
        lpfp_pkg::K_BODYLEN: begin
          if (take_be(b, 4)) begin
            r.flast = 1'b1;
            body_rem = acc;
            phase = (body_rem == 32'd0) ? lpfp_pkg::K_TRAIL : lpfp_pkg::K_BODY;
          end
        end
        lpfp_pkg::K_BODY: begin
          body_rem = body_rem - 32'd1;
          if (body_rem == 32'd0) begin
            r.flast = 1'b1;
            phase = lpfp_pkg::K_TRAIL;
          end
        end
        default: begin
          r.kind = lpfp_pkg::K_TRAIL;
          phase = lpfp_pkg::K_TRAIL;
          r.flast = last;
        end
      endcase

      if (last) begin
        // length check first, in 33 bits so an all-ones total cannot wrap
        want_seen = {1'b0, frame_total} + 33'(lpfp_pkg::PREFIX_BYTES);
        if (!total_known || want_seen != seen) r.status = lpfp_pkg::ST_LEN_ERR;
        else if (phase != lpfp_pkg::K_TRAIL) r.status = lpfp_pkg::ST_OVERRUN;
        else r.status = lpfp_pkg::ST_GOOD;
        clear();
      end
      expected_tags.insert(expected_tags.size(), r);
    endfunction

    function void check_result(logic [31:0] tdata, logic [3:0] tuser, logic tlast);
      lpfp_pkg::result_t want;
      if (expected_tags.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("[%0t] Output transaction with nothing pending: tdata %h tuser %h tlast %b",
                   $realtime, tdata, tuser, tlast);
        return;
      end
      want = expected_tags.pop_front();
      tags_checked++;
      kinds_seen[want.kind] = 1'b1;
      if (want.fend) ends_by_status[want.status]++;
      if (tdata[7:0] !== want.data || tdata[23:8] !== want.hnum ||
          tdata[24] !== want.flast || tdata[26:25] !== want.status ||
          tdata[31:27] !== 5'd0 || tuser !== want.kind || tlast !== want.fend) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $write("[%0t] Tag %0d mismatch: exp byte %h kind %0d hdr %0d flast %b end %b st %0d",
                 $realtime, tags_checked, want.data, want.kind, want.hnum, want.flast,
                 want.fend, want.status);
          $display(" | got byte %h kind %0d hdr %0d flast %b end %b st %0d pad %h",
                   tdata[7:0], tuser, tdata[23:8], tdata[24], tlast, tdata[26:25],
                   tdata[31:27]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals, instance
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  length_prefixed_frame_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  frame_tag_scoreboard tag_board = new();

  logic [7:0] frame_bytes[$];   // buffer being assembled
  int         bytes_sent = 0;
  int         buffers_sent = 0;
  int         idle_cycles = 0;
  bit         src_burst = 1'b0;
  bit         snk_burst = 1'b0;

  // --------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge. The input transaction
  // is scored before the output one so ordering never depends on the
  // simulator. Also the watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tag_board.predict_tag(s_tdata, s_tlast);
      if (m_tvalid && m_tready) tag_board.check_result(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d tags still pending",
                 idle_cycles, tag_board.expected_tags.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random ready gaps, with occasional stretches of none
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    int served;
    served = 0;
    while (rst) @(negedge clk);
    forever begin
      if (served % 32 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      gap = snk_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      served++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Frame assembly
  // --------------------------------------------------------------------------
  function void add_byte(logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  function void push_be(logic [31:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function void prepend_total(logic [31:0] v);
    for (int i = 0; i < 4; i++) frame_bytes.push_front(v[8*i +: 8]);
  endfunction

  // small lengths, or now and then any 16-bit value when cut frames are built
  function logic [15:0] pick_len(bit wild);
    if (wild && $urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 3));
  endfunction

  function void push_string(logic [15:0] len);
    push_be(32'(len), 2);
    for (int i = 0; i < len && frame_bytes.size() < PAYLOAD_CAP; i++)
      add_byte(8'($urandom));
  endfunction

  // everything after the total-length field
  function void build_payload(bit wild);
    logic [15:0] n_hdr;
    logic [31:0] n_body;
    add_byte(8'($urandom));                           // type
    push_string(pick_len(wild));                      // request id
    n_hdr = pick_len(wild);
    push_be(32'(n_hdr), 2);
    for (int h = 0; h < n_hdr && frame_bytes.size() < PAYLOAD_CAP; h++) begin
      push_string(pick_len(wild));                    // key
      push_string(pick_len(wild));                    // value
    end
    n_body = (wild && $urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6);
    push_be(n_body, 4);
    for (longint i = 0; i < n_body && frame_bytes.size() < PAYLOAD_CAP; i++)
      add_byte(8'($urandom));
  endfunction

  function buf_mode_t pick_mode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return BUF_GOOD;
    if (roll < 75) return BUF_CUT;
    if (roll < 85) return BUF_BAD_TOTAL;
    if (roll < 95) return BUF_NOISE;
    return BUF_SHORT;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task send_buffer();
    src_burst = ($urandom_range(0, 3) == 0);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    buffers_sent++;
  endtask

  task send_random_buffer();
    int          cut;
    int          n;
    logic [31:0] wrong;
    frame_bytes.delete();
    case (pick_mode())
      BUF_GOOD: begin
        build_payload(1'b0);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom));  // trailing
        prepend_total(32'(frame_bytes.size()));
      end
      BUF_CUT: begin
        // total matches the bytes sent, but the frame stops short of its end
        build_payload(1'b1);
        cut = $urandom_range(0, frame_bytes.size() - 1);
        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        prepend_total(32'(cut));
      end
      BUF_BAD_TOTAL: begin
        build_payload(1'b0);
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
        wrong = ($urandom_range(0, 1) == 0) ? $urandom
                                             : 32'(frame_bytes.size() + $urandom_range(1, 3));
        prepend_total(wrong);
      end
      BUF_NOISE: begin
        n = $urandom_range(1, 8);
        repeat (n) add_byte(8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(8'($urandom));
      end
    endcase
    send_buffer();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // short buffer: ends inside the total length
    frame_bytes = '{8'h00, 8'hFF};
    send_buffer();

    // one frame touching every field kind, one trailing byte
    frame_bytes.delete();
    add_byte(8'h5A);                    // type
    push_be(32'd1, 2);
    add_byte(8'hA5);                    // id
    push_be(32'd1, 2);                  // one header
    push_be(32'd1, 2);
    add_byte(8'h00);                    // key
    push_be(32'd1, 2);
    add_byte(8'h80);                    // value
    push_be(32'd1, 4);
    add_byte(8'h7F);                    // body
    add_byte(8'hC3);                    // trailing
    prepend_total(32'(frame_bytes.size()));
    send_buffer();

    // all-ones total: total + 4 must not wrap to match a tiny buffer
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_buffer();

    while (bytes_sent < NUM_BYTES) send_random_buffer();
    s_tvalid <= 1'b0;

    while (tag_board.expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (tag_board.expected_tags.size() != 0) begin
      tag_board.failures++;
      $display("%0d tags never came out", tag_board.expected_tags.size());
    end
    $display("Ran %0d bytes in %0d buffers; frame ends: %0d good, %0d length error, %0d overrun",
             bytes_sent, buffers_sent, tag_board.ends_by_status[lpfp_pkg::ST_GOOD],
             tag_board.ends_by_status[lpfp_pkg::ST_LEN_ERR],
             tag_board.ends_by_status[lpfp_pkg::ST_OVERRUN]);
    $display("Field kinds seen (bit per kind, 11 down to 0): %b, mismatches: %0d",
             tag_board.kinds_seen, tag_board.failures);
    if (tag_board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
